// ----- rtl/msie_pkg.sv -----
package msie_pkg;

    localparam int unsigned DATA_WORDS_DEF = 32;

    // Kind of word carried on the input channel.
    typedef enum logic [1:0] {
        OP_EXEC     = 2'd0,
        OP_LOAD_REG = 2'd1,
        OP_LOAD_MEM = 2'd2,
        OP_IDLE     = 2'd3
    } item_op_t;

    // Primary opcodes.
    localparam logic [5:0] OPC_RTYPE = 6'd0;
    localparam logic [5:0] OPC_J     = 6'd2;
    localparam logic [5:0] OPC_BEQ   = 6'd4;
    localparam logic [5:0] OPC_LW    = 6'd35;
    localparam logic [5:0] OPC_SW    = 6'd43;

    // Function codes of the register-register group.
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_NOR = 6'd39;
    localparam logic [5:0] FN_SLT = 6'd42;

    // One register file write, also kept as the bypass of the last write.
    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

endpackage

// ----- rtl/msie_regfile.sv -----
module msie_regfile
    import msie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  rd_addr_a,
    input  logic [4:0]  rd_addr_b,
    output logic [31:0] rd_data_a,
    output logic [31:0] rd_data_b,
    input  rf_wr_t      wr
);

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        rd_a_ok_reg;
    logic        rd_b_ok_reg;

    // An entry that was never written reads as zero; register 0 is never written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg    <= mem[rd_addr_a];
            rd_b_reg    <= mem[rd_addr_b];
            rd_a_ok_reg <= valid_reg[rd_addr_a];
            rd_b_ok_reg <= valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_ok_reg ? rd_a_reg : '0;
    assign rd_data_b = rd_b_ok_reg ? rd_b_reg : '0;

endmodule

// ----- rtl/msie_dmem.sv -----
module msie_dmem
    import msie_pkg::*;
#(
    parameter int unsigned DATA_WORDS = DATA_WORDS_DEF,
    localparam int unsigned AW = $clog2(DATA_WORDS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    output logic          busy
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DATA_WORDS - 1);

    logic [31:0]   mem [DATA_WORDS];
    logic [31:0]   rd_data_reg;
    logic          clearing_reg;
    logic          clearing_next;
    logic [AW-1:0] clr_idx_reg;
    logic [AW-1:0] clr_idx_next;

    // After reset every word is zeroed, one per cycle.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            if (clr_idx_reg == LAST_IDX)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// ----- rtl/msie_word_index.sv -----
module msie_word_index
    import msie_pkg::*;
#(
    parameter int unsigned DATA_WORDS = DATA_WORDS_DEF,
    localparam int unsigned AW = $clog2(DATA_WORDS)
)
(
    input  logic [29:0]   word_addr,
    output logic [AW-1:0] index
);

    typedef logic [3:0][255:0][AW-1:0] residue_tab_t;

    // Residue of each byte digit at each position, built at elaboration by
    // repeated addition so that no division is involved.
    function automatic residue_tab_t build_residues();
        residue_tab_t tab;
        int unsigned  weight;
        int unsigned  acc;
        int unsigned  nxt;
        tab    = '0;
        weight = 1;
        for (int pos = 0; pos < 4; pos++)
        begin
            acc = 0;
            for (int d = 0; d < 256; d++)
            begin
                tab[pos][d] = AW'(acc);
                acc = acc + weight;
                if (acc >= DATA_WORDS)
                begin
                    acc = acc - DATA_WORDS;
                end
            end
            nxt = 0;
            for (int k = 0; k < 256; k++)
            begin
                nxt = nxt + weight;
                if (nxt >= DATA_WORDS)
                begin
                    nxt = nxt - DATA_WORDS;
                end
            end
            weight = nxt;
        end
        return tab;
    endfunction

    if ((DATA_WORDS & (DATA_WORDS - 1)) == 0)
    begin : g_pow2
        assign index = word_addr[AW-1:0];
    end
    else
    begin : g_residue
        localparam residue_tab_t RES_TAB = build_residues();
        localparam logic [AW+1:0] ONE_D  = (AW+2)'(DATA_WORDS);
        localparam logic [AW+1:0] TWO_D  = (AW+2)'(2 * DATA_WORDS);

        logic [AW+1:0] sum;
        logic [AW+1:0] part;
        logic [AW+1:0] rem;

        // The four residues add to less than four times the depth.
        assign sum = (AW+2)'(RES_TAB[0][word_addr[7:0]])
                   + (AW+2)'(RES_TAB[1][word_addr[15:8]])
                   + (AW+2)'(RES_TAB[2][word_addr[23:16]])
                   + (AW+2)'(RES_TAB[3][{2'b00, word_addr[29:24]}]);
        assign part  = (sum >= TWO_D) ? sum - TWO_D : sum;
        assign rem   = (part >= ONE_D) ? part - ONE_D : part;
        assign index = rem[AW-1:0];
    end

endmodule

// ----- rtl/mips_subset_instruction_executor.sv -----
// Executes a small MIPS subset (add, sub, and, or, nor, slt, lw, sw, beq, j)
// one word at a time, keeping the program counter, 32 registers and a
// word-addressed data memory of DATA_WORDS entries.
// Input channel: in_valid/in_ready with op, instruction, preload_index and
// preload_value. op selects execute, register preload, memory preload or idle.
// Output channel: out_valid/out_ready with one result word per input word.
// A word accepted is registered in the execute stage, then in the output stage.
// Throughput: one word per cycle unless out_ready is low or memory is cleared;
// register reads, operand bypass and the data memory port each finish in one
// stage.
// Reset: the program counter and registers read as zero at once; the data
// memory is swept to zero word by word, during which in_ready is low.
// When the receiver stalls, the result stays in the output register and the
// execute stage behind it holds; in_ready drops until out_ready returns.
module mips_subset_instruction_executor
    import msie_pkg::*;
#(
    parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [31:0]        instruction,
    input  logic [4:0]         preload_index,
    input  logic signed [31:0] preload_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        next_pc,
    output logic               reg_written,
    output logic [4:0]         reg_index,
    output logic signed [31:0] reg_value,
    output logic               mem_written,
    output logic [4:0]         mem_index,
    output logic signed [31:0] mem_value,
    output logic               branch_taken,
    output logic               program_end,
    output logic               unknown_instruction
);

    localparam int unsigned AW = $clog2(DATA_WORDS);

    logic        adv;
    logic        accept;
    logic        dm_busy;

    // Execute stage
    logic        s1_valid_reg;
    item_op_t    s1_op_reg;
    logic [31:0] s1_instr_reg;
    logic [4:0]  s1_pidx_reg;
    logic [31:0] s1_pval_reg;
    logic [31:0] pc_reg;

    // Output stage
    logic        s2_valid_reg;
    logic [31:0] s2_npc_reg;
    logic        s2_rw_reg;
    logic [4:0]  s2_ridx_reg;
    logic [31:0] s2_rval_reg;
    logic        s2_load_reg;
    logic        s2_mw_reg;
    logic [4:0]  s2_midx_reg;
    logic [31:0] s2_mval_reg;
    logic        s2_taken_reg;
    logic        s2_end_reg;
    logic        s2_unk_reg;

    rf_wr_t      pending_wr;
    rf_wr_t      rf_wr;
    rf_wr_t      last_wr_reg;

    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic [31:0] dm_rdata;
    logic [31:0] wb_value;

    logic [5:0]  opcode;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  funct;
    logic [31:0] simm;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [31:0] pc4;
    logic [31:0] eff_addr;
    logic [29:0] idx_src;
    logic [AW-1:0] dm_index;
    logic [AW+4:0] dm_index_wide;

    logic [31:0] s1_npc;
    logic        s1_rw;
    logic [4:0]  s1_ridx;
    logic [31:0] s1_rval;
    logic        s1_load;
    logic        s1_mw;
    logic [31:0] s1_mval;
    logic        s1_taken;
    logic        s1_end;
    logic        s1_unk;

    assign adv      = !s2_valid_reg || out_ready;
    assign in_ready = adv && !dm_busy;
    assign accept   = in_valid && in_ready;

    msie_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (adv),
        .rd_addr_a (instruction[25:21]),
        .rd_addr_b (instruction[20:16]),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr        (rf_wr)
    );

    // ---------------- execute stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= item_op_t'(op);
            s1_instr_reg <= instruction;
            s1_pidx_reg  <= preload_index;
            s1_pval_reg  <= preload_value;
        end
    end

    assign opcode = s1_instr_reg[31:26];
    assign rs     = s1_instr_reg[25:21];
    assign rt     = s1_instr_reg[20:16];
    assign rd     = s1_instr_reg[15:11];
    assign funct  = s1_instr_reg[5:0];
    assign simm   = {{16{s1_instr_reg[15]}}, s1_instr_reg[15:0]};
    assign pc4    = pc_reg + 32'd4;

    // The word in the output stage has not reached the register file yet, and
    // the write made at the edge of the operand read was missed by that read.
    assign wb_value   = (s2_load_reg && s2_rw_reg) ? dm_rdata : s2_rval_reg;
    assign pending_wr = '{en: s2_valid_reg && s2_rw_reg, idx: s2_ridx_reg, data: wb_value};
    assign rf_wr      = '{en: pending_wr.en && adv, idx: pending_wr.idx, data: pending_wr.data};

    always_comb
    begin
        opa = rf_a;
        if (pending_wr.en && pending_wr.idx == rs)
        begin
            opa = pending_wr.data;
        end
        else if (last_wr_reg.en && last_wr_reg.idx == rs)
        begin
            opa = last_wr_reg.data;
        end
    end

    always_comb
    begin
        opb = rf_b;
        if (pending_wr.en && pending_wr.idx == rt)
        begin
            opb = pending_wr.data;
        end
        else if (last_wr_reg.en && last_wr_reg.idx == rt)
        begin
            opb = last_wr_reg.data;
        end
    end

    assign eff_addr = opa + simm;
    assign idx_src  = (s1_op_reg == OP_LOAD_MEM) ? {25'd0, s1_pidx_reg} : eff_addr[31:2];

    msie_word_index #(
        .DATA_WORDS (DATA_WORDS)
    ) u_word_index (
        .word_addr (idx_src),
        .index     (dm_index)
    );

    assign dm_index_wide = (AW+5)'(dm_index);

    always_comb
    begin
        s1_npc   = pc_reg;
        s1_rw    = 1'b0;
        s1_ridx  = '0;
        s1_rval  = '0;
        s1_load  = 1'b0;
        s1_mw    = 1'b0;
        s1_mval  = '0;
        s1_taken = 1'b0;
        s1_end   = 1'b0;
        s1_unk   = 1'b0;
        unique case (s1_op_reg)
            OP_LOAD_REG:
            begin
                if (s1_pidx_reg != 5'd0)
                begin
                    s1_rw   = 1'b1;
                    s1_ridx = s1_pidx_reg;
                    s1_rval = s1_pval_reg;
                end
            end
            OP_LOAD_MEM:
            begin
                s1_mw   = 1'b1;
                s1_mval = s1_pval_reg;
            end
            OP_EXEC:
            begin
                if (s1_instr_reg == 32'd0)
                begin
                    s1_end = 1'b1;
                end
                else
                begin
                    s1_npc = pc4;
                    case (opcode)
                        OPC_RTYPE:
                        begin
                            s1_rw   = (rd != 5'd0);
                            s1_ridx = (rd != 5'd0) ? rd : 5'd0;
                            case (funct)
                                FN_ADD: s1_rval = opa + opb;
                                FN_SUB: s1_rval = opa - opb;
                                FN_AND: s1_rval = opa & opb;
                                FN_OR:  s1_rval = opa | opb;
                                FN_NOR: s1_rval = ~(opa | opb);
                                FN_SLT: s1_rval = {31'd0, $signed(opa) < $signed(opb)};
                                default:
                                begin
                                    s1_rw   = 1'b0;
                                    s1_ridx = '0;
                                    s1_unk  = 1'b1;
                                end
                            endcase
                            if (!s1_rw)
                            begin
                                s1_rval = '0;
                            end
                        end
                        OPC_LW:
                        begin
                            s1_rw   = (rt != 5'd0);
                            s1_load = (rt != 5'd0);
                            s1_ridx = (rt != 5'd0) ? rt : 5'd0;
                        end
                        OPC_SW:
                        begin
                            s1_mw   = 1'b1;
                            s1_mval = opb;
                        end
                        OPC_BEQ:
                        begin
                            if (opa == opb)
                            begin
                                s1_taken = 1'b1;
                                s1_npc   = pc4 + {simm[29:0], 2'b00};
                            end
                        end
                        OPC_J:
                        begin
                            s1_taken = 1'b1;
                            s1_npc   = {pc4[31:28], s1_instr_reg[25:0], 2'b00};
                        end
                        default:
                        begin
                            s1_unk = 1'b1;
                        end
                    endcase
                end
            end
            OP_IDLE:
            begin
            end
        endcase
    end

    msie_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (dm_index),
        .rd_data (dm_rdata),
        .wr_en   (adv && s1_valid_reg && s1_mw),
        .wr_addr (dm_index),
        .wr_data (s1_mval),
        .busy    (dm_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            pc_reg <= s1_npc;
        end
    end

    // ---------------- output stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            last_wr_reg  <= '0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            last_wr_reg  <= pending_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_npc_reg   <= s1_npc;
            s2_rw_reg    <= s1_rw;
            s2_ridx_reg  <= s1_ridx;
            s2_rval_reg  <= s1_rval;
            s2_load_reg  <= s1_load;
            s2_mw_reg    <= s1_mw;
            s2_midx_reg  <= s1_mw ? dm_index_wide[4:0] : 5'd0;
            s2_mval_reg  <= s1_mval;
            s2_taken_reg <= s1_taken;
            s2_end_reg   <= s1_end;
            s2_unk_reg   <= s1_unk;
        end
    end

    assign out_valid           = s2_valid_reg;
    assign next_pc             = s2_npc_reg;
    assign reg_written         = s2_rw_reg;
    assign reg_index           = s2_ridx_reg;
    assign reg_value           = $signed(wb_value);
    assign mem_written         = s2_mw_reg;
    assign mem_index           = s2_midx_reg;
    assign mem_value           = $signed(s2_mval_reg);
    assign branch_taken        = s2_taken_reg;
    assign program_end         = s2_end_reg;
    assign unknown_instruction = s2_unk_reg;

    // ---------------- assertions ----------------
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        dm_busy |-> !in_ready && !s1_valid_reg && !s2_valid_reg
    ) else $error("word taken while the data memory is being cleared");

    a_no_write_to_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> rf_wr.idx != 5'd0
    ) else $error("register 0 written");

    a_end_has_no_effect: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && program_end |->
            !reg_written && !mem_written && !branch_taken && !unknown_instruction
    ) else $error("program end word changed state");

    a_pc_held_by_preload: assert property (
        @(posedge clk) disable iff (!rst_n)
        adv && s1_valid_reg && s1_op_reg != OP_EXEC |=> pc_reg == $past(pc_reg)
    ) else $error("program counter moved on a non-execute word");

    a_single_store_kind: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reg_written && mem_written)
    ) else $error("one word wrote both a register and memory");

endmodule

// ----- bench/msie_retire_checker.sv -----
module msie_retire_checker
    import msie_pkg::*;
#(
    parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] instruction,
    input  logic [4:0]  preload_index,
    input  logic [31:0] preload_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] next_pc,
    input  logic        reg_written,
    input  logic [4:0]  reg_index,
    input  logic [31:0] reg_value,
    input  logic        mem_written,
    input  logic [4:0]  mem_index,
    input  logic [31:0] mem_value,
    input  logic        branch_taken,
    input  logic        program_end,
    input  logic        unknown_instruction,
    output int          outstanding,
    output int          results_seen,
    output int          mismatches
);

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [4:0]  mem_index;
        logic [31:0] mem_value;
        logic        branch_taken;
        logic        program_end;
        logic        unknown_instruction;
    } retire_t;

    logic [31:0] pc_q;
    logic [31:0] gpr [32];
    logic [31:0] dmem [DATA_WORDS];
    retire_t     retire_q [$];

    function automatic logic [31:0] word_slot(input logic [31:0] addr);
        return (addr >> 2) % DATA_WORDS;
    endfunction

    // Applies one word to the shadow state and returns the result it retires.
    function automatic retire_t execute_word(input item_op_t kind, input logic [31:0] word,
                                             input logic [4:0] pidx, input logic [31:0] pval);
        retire_t     r;
        logic [5:0]  opcode;
        logic [5:0]  funct;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] simm;
        logic [31:0] pc4;
        logic [31:0] val;
        logic [31:0] slot;
        logic        wr;
        r      = '0;
        opcode = word[31:26];
        funct  = word[5:0];
        rs     = word[25:21];
        rt     = word[20:16];
        simm   = {{16{word[15]}}, word[15:0]};
        a      = gpr[rs];
        b      = gpr[rt];
        pc4    = pc_q + 32'd4;
        wr     = 1'b0;
        dest   = '0;
        val    = '0;
        r.next_pc = pc_q;
        case (kind)
            OP_LOAD_REG:
            begin
                if (pidx != 0)
                begin
                    gpr[pidx]     = pval;
                    r.reg_written = 1'b1;
                    r.reg_index   = pidx;
                    r.reg_value   = pval;
                end
            end
            OP_LOAD_MEM:
            begin
                slot          = pidx % DATA_WORDS;
                dmem[slot]    = pval;
                r.mem_written = 1'b1;
                r.mem_index   = slot[4:0];
                r.mem_value   = pval;
            end
            OP_EXEC:
            begin
                if (word == 0)
                begin
                    r.program_end = 1'b1;
                end
                else
                begin
                    r.next_pc = pc4;
                    case (opcode)
                        OPC_RTYPE:
                        begin
                            wr   = 1'b1;
                            dest = word[15:11];
                            case (funct)
                                FN_ADD:  val = a + b;
                                FN_SUB:  val = a - b;
                                FN_AND:  val = a & b;
                                FN_OR:   val = a | b;
                                FN_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                                FN_NOR:  val = ~(a | b);
                                default:
                                begin
                                    wr                    = 1'b0;
                                    r.unknown_instruction = 1'b1;
                                end
                            endcase
                        end
                        OPC_LW:
                        begin
                            wr   = 1'b1;
                            dest = rt;
                            val  = dmem[word_slot(a + simm)];
                        end
                        OPC_SW:
                        begin
                            slot          = word_slot(a + simm);
                            dmem[slot]    = b;
                            r.mem_written = 1'b1;
                            r.mem_index   = slot[4:0];
                            r.mem_value   = b;
                        end
                        OPC_BEQ:
                        begin
                            if (a == b)
                            begin
                                r.branch_taken = 1'b1;
                                r.next_pc      = pc4 + (simm << 2);
                            end
                        end
                        OPC_J:
                        begin
                            r.branch_taken = 1'b1;
                            r.next_pc      = {pc4[31:28], word[25:0], 2'b00};
                        end
                        default: r.unknown_instruction = 1'b1;
                    endcase
                    // Register 0 is hardwired, so a write to it leaves no trace.
                    if (wr && dest != 0)
                    begin
                        gpr[dest]     = val;
                        r.reg_written = 1'b1;
                        r.reg_index   = dest;
                        r.reg_value   = val;
                    end
                end
            end
            default: ;
        endcase
        pc_q = r.next_pc;
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        retire_t want;
        int      bad;
        if (!rst_n)
        begin
            pc_q = '0;
            for (int i = 0; i < 32; i++)
                gpr[i] = '0;
            for (int i = 0; i < DATA_WORDS; i++)
                dmem[i] = '0;
            retire_q.delete();
            results_seen = 0;
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (retire_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, actual next_pc %h",
                             $time, next_pc);
                    mismatches++;
                end
                else
                begin
                    want = retire_q.pop_front();
                    bad  = field_diff("next_pc", want.next_pc, next_pc)
                         + field_diff("reg_written", 32'(want.reg_written), 32'(reg_written))
                         + field_diff("reg_index", 32'(want.reg_index), 32'(reg_index))
                         + field_diff("reg_value", want.reg_value, reg_value)
                         + field_diff("mem_written", 32'(want.mem_written), 32'(mem_written))
                         + field_diff("mem_index", 32'(want.mem_index), 32'(mem_index))
                         + field_diff("mem_value", want.mem_value, mem_value)
                         + field_diff("branch_taken", 32'(want.branch_taken),
                                      32'(branch_taken))
                         + field_diff("program_end", 32'(want.program_end),
                                      32'(program_end))
                         + field_diff("unknown_instruction", 32'(want.unknown_instruction),
                                      32'(unknown_instruction));
                    if (bad != 0)
                        mismatches++;
                end
            end
            if (in_valid && in_ready)
                retire_q.push_back(execute_word(item_op_t'(op), instruction,
                                                preload_index, preload_value));
            outstanding <= retire_q.size();
        end
    end

endmodule

// ----- bench/mips_subset_instruction_executor_tb.sv -----
module mips_subset_instruction_executor_tb;
    import msie_pkg::*;

    localparam int unsigned DATA_WORDS   = DATA_WORDS_DEF;
    localparam int          RANDOM_WORDS = 120;
    localparam int          HOLD_CYCLES  = 150;
    // Codes that the block does not support.
    localparam logic [5:0]  FN_SLL       = 6'd0;
    localparam logic [5:0]  OPC_UNUSED   = 6'h3f;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    item_op_t    op;
    logic [31:0] instruction;
    logic [4:0]  preload_index;
    logic [31:0] preload_value;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [4:0]  mem_index;
    logic [31:0] mem_value;
    logic        branch_taken;
    logic        program_end;
    logic        unknown_instruction;

    int   outstanding;
    int   results_seen;
    int   mismatches;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_off  = 1'b0;
    logic pressure_go;
    int   n_exec = 0;
    int   n_reg  = 0;
    int   n_mem  = 0;
    int   n_nop  = 0;

    mips_subset_instruction_executor #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .op                  (op),
        .instruction         (instruction),
        .preload_index       (preload_index),
        .preload_value       (preload_value),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .next_pc             (next_pc),
        .reg_written         (reg_written),
        .reg_index           (reg_index),
        .reg_value           (reg_value),
        .mem_written         (mem_written),
        .mem_index           (mem_index),
        .mem_value           (mem_value),
        .branch_taken        (branch_taken),
        .program_end         (program_end),
        .unknown_instruction (unknown_instruction)
    );

    msie_retire_checker #(
        .DATA_WORDS (DATA_WORDS)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .op                  (op),
        .instruction         (instruction),
        .preload_index       (preload_index),
        .preload_value       (preload_value),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .next_pc             (next_pc),
        .reg_written         (reg_written),
        .reg_index           (reg_index),
        .reg_value           (reg_value),
        .mem_written         (mem_written),
        .mem_index           (mem_index),
        .mem_value           (mem_value),
        .branch_taken        (branch_taken),
        .program_end         (program_end),
        .unknown_instruction (unknown_instruction),
        .outstanding         (outstanding),
        .results_seen        (results_seen),
        .mismatches          (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Long output hold-off so that the pipeline fills and in_ready drops.
    initial
    begin
        wait (pressure_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic logic [31:0] encode_r(input logic [4:0] rs, input logic [4:0] rt,
                                             input logic [4:0] rd, input logic [5:0] funct);
        return {OPC_RTYPE, rs, rt, rd, 5'd0, funct};
    endfunction

    function automatic logic [31:0] encode_i(input logic [5:0] opcode, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [15:0] imm);
        return {opcode, rs, rt, imm};
    endfunction

    function automatic logic [31:0] encode_j(input logic [25:0] target);
        return {OPC_J, target};
    endfunction

    task automatic issue_word(input item_op_t kind, input logic [31:0] word,
                              input logic [4:0] idx, input logic [31:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= kind;
        instruction   <= word;
        preload_index <= idx;
        preload_value <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        case (kind)
            OP_EXEC:     n_exec++;
            OP_LOAD_REG: n_reg++;
            OP_LOAD_MEM: n_mem++;
            default:     n_nop++;
        endcase
    endtask

    initial
    begin
        int          pick;
        item_op_t    kind;
        logic [31:0] word;
        logic [31:0] value;
        logic [5:0]  code;
        logic [4:0]  rs;
        logic [4:0]  rt;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_EXEC;
        instruction   = '0;
        preload_index = '0;
        preload_value = '0;
        pressure_go   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        issue_word(OP_LOAD_REG, '0, 5'd1, 32'h7fff_ffff);
        issue_word(OP_LOAD_REG, '0, 5'd2, 32'h8000_0000);
        issue_word(OP_LOAD_REG, '1, 5'd3, 32'hffff_ffff);
        issue_word(OP_LOAD_REG, '0, 5'd0, 32'h1234_5678);
        issue_word(OP_LOAD_MEM, '0, 5'd31, 32'h5a5a_0f0f);
        issue_word(OP_LOAD_MEM, '1, 5'd0, 32'h8000_0000);
        // Addition and subtraction wrap without any trap.
        issue_word(OP_EXEC, encode_r(5'd1, 5'd1, 5'd4, FN_ADD), 5'd31, 32'hffff_ffff);
        issue_word(OP_EXEC, encode_r(5'd2, 5'd1, 5'd5, FN_SUB), '0, '0);
        issue_word(OP_EXEC, encode_r(5'd3, 5'd1, 5'd6, FN_AND), '0, '0);
        issue_word(OP_EXEC, encode_r(5'd2, 5'd1, 5'd7, FN_OR), '0, '0);
        issue_word(OP_EXEC, encode_r(5'd2, 5'd1, 5'd8, FN_SLT), '0, '0);
        issue_word(OP_EXEC, encode_r(5'd1, 5'd2, 5'd9, FN_SLT), '0, '0);
        issue_word(OP_EXEC, encode_r(5'd0, 5'd0, 5'd10, FN_NOR), '0, '0);
        issue_word(OP_EXEC, encode_r(5'd1, 5'd3, 5'd0, FN_ADD), '0, '0);
        issue_word(OP_EXEC, encode_i(OPC_LW, 5'd0, 5'd11, 16'hfffc), '0, '0);
        issue_word(OP_EXEC, encode_i(OPC_SW, 5'd0, 5'd3, 16'h7ffc), '0, '0);
        issue_word(OP_EXEC, encode_i(OPC_LW, 5'd1, 5'd0, 16'h0000), '0, '0);
        issue_word(OP_EXEC, encode_i(OPC_BEQ, 5'd0, 5'd0, 16'hffff), '0, '0);
        issue_word(OP_EXEC, encode_i(OPC_BEQ, 5'd1, 5'd2, 16'h7fff), '0, '0);
        issue_word(OP_EXEC, encode_j(26'h3ff_ffff), '0, '0);
        issue_word(OP_EXEC, {OPC_UNUSED, 26'h155_5555}, '0, '0);
        issue_word(OP_EXEC, encode_r(5'd1, 5'd2, 5'd12, FN_SLL), '0, '0);
        issue_word(OP_EXEC, '0, 5'd31, 32'hffff_ffff);
        issue_word(OP_IDLE, '1, 5'd31, 32'hffff_ffff);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct   = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct   = 61;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct   = 0;
                    stall_pct <= 61;
                end
                default:
                begin
                    idle_pct   = 13;
                    stall_pct <= 13;
                end
            endcase
            for (int n = 0; n < RANDOM_WORDS; n++)
            begin
                if (phase == 0 && n == 20)
                    pressure_go = 1'b1;
                pick = $urandom_range(99);
                if (pick < 70)
                    kind = OP_EXEC;
                else if (pick < 83)
                    kind = OP_LOAD_REG;
                else if (pick < 95)
                    kind = OP_LOAD_MEM;
                else
                    kind = OP_IDLE;

                rs   = 5'($urandom_range(31));
                rt   = 5'($urandom_range(31));
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    case ($urandom_range(5))
                        0:       code = FN_ADD;
                        1:       code = FN_SUB;
                        2:       code = FN_AND;
                        3:       code = FN_OR;
                        4:       code = FN_SLT;
                        default: code = FN_NOR;
                    endcase
                    word = encode_r(rs, rt, 5'($urandom_range(31)), code)
                         | ($urandom_range(31) << 6);
                end
                else if (pick < 55)
                    word = encode_i(OPC_LW, rs, rt, 16'($urandom_range(16'hffff)));
                else if (pick < 70)
                    word = encode_i(OPC_SW, rs, rt, 16'($urandom_range(16'hffff)));
                else if (pick < 80)
                begin
                    // Comparing a register with itself makes taken branches common.
                    if ($urandom_range(1) == 1)
                        rt = rs;
                    word = encode_i(OPC_BEQ, rs, rt, 16'($urandom_range(16'hffff)));
                end
                else if (pick < 86)
                    word = encode_j(26'($urandom_range(26'h3ff_ffff)));
                else if (pick < 90)
                begin
                    do
                        code = 6'($urandom_range(63));
                    while (code == FN_ADD || code == FN_SUB || code == FN_AND ||
                           code == FN_OR || code == FN_SLT || code == FN_NOR);
                    word = encode_r(rs, rt, 5'($urandom_range(31)), code);
                end
                else if (pick < 94)
                begin
                    do
                        code = 6'($urandom_range(63));
                    while (code == OPC_RTYPE || code == OPC_J || code == OPC_BEQ ||
                           code == OPC_LW || code == OPC_SW);
                    word          = $urandom;
                    word[31:26]   = code;
                end
                else if (pick < 96)
                    word = '0;
                else
                    word = $urandom;

                case ($urandom_range(9))
                    0:       value = 32'h7fff_ffff;
                    1:       value = 32'h8000_0000;
                    2:       value = '0;
                    3:       value = '1;
                    default: value = $urandom;
                endcase
                issue_word(kind, word, 5'($urandom_range(31)), value);
            end
        end

        in_valid  <= 1'b0;
        stall_pct <= 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d words: %0d executed, %0d register preloads, %0d memory",
                 n_exec + n_reg + n_mem + n_nop, n_exec, n_reg, n_mem);
        $display("preloads, %0d idle ops, four idle/stall mixes and a long output hold-off;",
                 n_nop);
        $display("%0d results, %0d bad.", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/msie_pkg.sv
rtl/msie_regfile.sv
rtl/msie_dmem.sv
rtl/msie_word_index.sv
rtl/mips_subset_instruction_executor.sv
bench/msie_retire_checker.sv
bench/mips_subset_instruction_executor_tb.sv
